// ===== rtl/tkp_pkg.sv =====
// shared types and constants for the inner-product top-k search block
// no dependencies; imported by tkp_mac, tkp_max, the top level and the testbench
package tkp_pkg;

   localparam int DEF_MAX_ENTRIES  = 64;
   localparam int DEF_VECTOR_LEN   = 1024;
   localparam int DEF_ELEMENT_BITS = 16;

   localparam int TAG_W   = 31;
   localparam int SCORE_W = 41;
   localparam int ELEM_W  = 16;
   localparam int LIMIT_W = 7;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic valid;
      logic use_elem;
   } mac_ctrl_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } cmp_ctrl_type;

endpackage

// ===== rtl/dot_product_top_k_search_top.sv =====
// inner-product top-k search: vector store, sequencer and result ranking
// depends on tkp_pkg, tkp_mac, tkp_max
//
// req channel: one word per vector element. tuser is the command (add or
// query), tlast ends a vector. An add word is written when accepted. A query
// word runs the shared multiply-accumulate unit over every stored entry, one
// store read per entry, then lets the pipeline empty, with req_tready low
// throughout (with no entries it goes straight to the drain). The last
// query word then ranks: each result is one pass of the compare unit over all
// entries, then the word waits on rsp. req_tready is
// low from a query word until its work and all its results are done.
// rsp channel: up to result limit words in descending score order, tlast on
// the final one; a stall on rsp_tready simply holds the word and the block.
// csr channel: writes result_limit, always ready.
// reset empties the store, clears scores and sets result_limit to 64.
module dot_product_top_k_search_top
   import tkp_pkg::*;
#(
   parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
   parameter int VECTOR_LEN   = DEF_VECTOR_LEN,
   parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // tag[30:0], element[46:31], zero pad
   input  logic                  req_tuser,  // command
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // result_tag[30:0], score[71:31]
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LIMIT_W-1:0]    csr_data
);
   localparam int DEPTH = MAX_ENTRIES * VECTOR_LEN;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int PW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
   localparam int LW = $clog2(VECTOR_LEN + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MAC   = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_SWAIT = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic signed [ELEMENT_BITS-1:0] store_mem [DEPTH];
   logic [LW-1:0]                  len_mem   [MAX_ENTRIES];
   logic [TAG_W-1:0]               tag_mem   [MAX_ENTRIES];
   logic signed [SCORE_W-1:0]      sums_mem  [MAX_ENTRIES];

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] add_pos_ff, add_pos_in;
   logic [AW-1:0] add_base_ff, add_base_in;
   logic [PW-1:0] qpos_ff, qpos_in;
   logic signed [ELEMENT_BITS-1:0] value_ff, value_in;
   logic          qlast_ff, qlast_in;
   logic [EW-1:0] i_ff, i_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          p1_ff, p1_in;
   logic          p1_scan_ff, p1_scan_in;
   logic [EW-1:0] p1_idx_ff, p1_idx_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [LIMIT_W-1:0] n_ff, n_in;
   logic [LIMIT_W-1:0] k_ff, k_in;
   logic [MAX_ENTRIES-1:0] sv_valid_ff, sv_valid_in;
   logic [MAX_ENTRIES-1:0] sel_ff, sel_in;

   logic signed [ELEMENT_BITS-1:0] elem_q;
   logic [LW-1:0]                  len_q;
   logic signed [SCORE_W-1:0]      sum_q;
   logic [TAG_W-1:0]               tag_q;

   logic req_fire, add_we, add_end, tag_rd;
   logic mac_issue, scan_issue;
   logic signed [ELEMENT_BITS-1:0] elem_in;
   logic [31:0]    elem_ext;
   logic [LIMIT_W-1:0] count_lim, n_sel;
   logic           last_i;
   logic signed [SCORE_W-1:0] p1_sum;

   mac_ctrl_type mac_ctrl;
   cmp_ctrl_type cmp_ctrl;
   logic                      wr_valid;
   logic [EW-1:0]             wr_idx;
   logic signed [SCORE_W-1:0] wr_sum;
   logic [EW-1:0]             best_idx;
   logic signed [SCORE_W-1:0] best_score;

   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign elem_ext  = {16'b0, req_tdata[46:31]};
   assign elem_in   = elem_ext[ELEMENT_BITS-1:0];
   assign add_end   = req_tlast || (add_pos_ff == PW'(VECTOR_LEN - 1));
   assign add_we    = req_fire && (req_tuser == CMD_ADD) && (count_ff < CW'(MAX_ENTRIES));
   assign count_lim = LIMIT_W'(count_ff);
   assign n_sel     = (limit_ff < count_lim) ? limit_ff : count_lim;
   assign last_i    = (CW'(CW'(i_ff) + CW'(1)) == count_ff);
   assign p1_sum    = sv_valid_ff[p1_idx_ff] ? sum_q : '0;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      add_pos_in  = add_pos_ff;
      add_base_in = add_base_ff;
      qpos_in     = qpos_ff;
      value_in    = value_ff;
      qlast_in    = qlast_ff;
      i_in        = i_ff;
      addr_in     = addr_ff;
      n_in        = n_ff;
      k_in        = k_ff;
      sv_valid_in = sv_valid_ff;
      sel_in      = sel_ff;
      limit_in    = csr_valid ? csr_data : limit_ff;
      mac_issue   = 1'b0;
      scan_issue  = 1'b0;
      tag_rd      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tuser == CMD_ADD) begin
               if (add_we) begin
                  if (add_end) begin
                     count_in    = CW'(count_ff + CW'(1));
                     add_pos_in  = '0;
                     add_base_in = AW'(add_base_ff + AW'(VECTOR_LEN));
                  end else begin
                     add_pos_in = PW'(add_pos_ff + PW'(1));
                  end
               end
            end else if (req_fire) begin
               value_in = elem_in;
               qlast_in = req_tlast || (qpos_ff == PW'(VECTOR_LEN - 1));
               if (qpos_ff == '0) begin
                  sv_valid_in = '0;
               end
               i_in     = '0;
               addr_in  = AW'(qpos_ff);
               state_in = (count_ff == '0) ? ST_DRAIN : ST_MAC;
            end
         end
         ST_MAC: begin
            mac_issue = 1'b1;
            addr_in   = AW'(addr_ff + AW'(VECTOR_LEN));
            i_in      = EW'(i_ff + EW'(1));
            if (last_i) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p1_ff && !wr_valid) begin
               if (qlast_ff) begin
                  n_in = n_sel;
                  k_in = '0;
                  i_in = '0;
                  if (n_sel == '0) begin
                     qpos_in  = '0;
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  qpos_in  = PW'(qpos_ff + PW'(1));
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            scan_issue = 1'b1;
            i_in       = EW'(i_ff + EW'(1));
            if (last_i) begin
               state_in = ST_SWAIT;
            end
         end
         ST_SWAIT: begin
            if (!p1_ff) begin
               tag_rd           = 1'b1;
               sel_in[best_idx] = 1'b1;
               state_in         = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               if (LIMIT_W'(k_ff + LIMIT_W'(1)) == n_ff) begin
                  sel_in   = '0;
                  qpos_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = LIMIT_W'(k_ff + LIMIT_W'(1));
                  i_in     = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (wr_valid) begin
         sv_valid_in[wr_idx] = 1'b1;
      end
      p1_in      = mac_issue || scan_issue;
      p1_scan_in = scan_issue;
      p1_idx_in  = i_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         add_pos_ff  <= '0;
         add_base_ff <= '0;
         qpos_ff     <= '0;
         qlast_ff    <= 1'b0;
         i_ff        <= '0;
         p1_ff       <= 1'b0;
         p1_scan_ff  <= 1'b0;
         limit_ff    <= LIMIT_RESET;
         n_ff        <= '0;
         k_ff        <= '0;
         sv_valid_ff <= '0;
         sel_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         add_pos_ff  <= add_pos_in;
         add_base_ff <= add_base_in;
         qpos_ff     <= qpos_in;
         qlast_ff    <= qlast_in;
         i_ff        <= i_in;
         p1_ff       <= p1_in;
         p1_scan_ff  <= p1_scan_in;
         limit_ff    <= limit_in;
         n_ff        <= n_in;
         k_ff        <= k_in;
         sv_valid_ff <= sv_valid_in;
         sel_ff      <= sel_in;
      end
      value_ff  <= value_in;
      addr_ff   <= addr_in;
      p1_idx_ff <= p1_idx_in;
   end

   // store writes and registered reads
   always_ff @(posedge clock) begin
      if (add_we) begin
         store_mem[AW'(add_base_ff + AW'(add_pos_ff))] <= elem_in;
      end
      if (mac_issue) begin
         elem_q <= store_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (add_we) begin
         tag_mem[EW'(count_ff)] <= req_tdata[TAG_W-1:0];
         if (add_end) begin
            len_mem[EW'(count_ff)] <= LW'(LW'(add_pos_ff) + LW'(1));
         end
      end
      if (mac_issue) begin
         len_q <= len_mem[i_ff];
      end
      if (tag_rd) begin
         tag_q <= tag_mem[best_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         sums_mem[wr_idx] <= wr_sum;
      end
      if (mac_issue || scan_issue) begin
         sum_q <= sums_mem[i_ff];
      end
   end

   // positions past a short vector count as zero
   assign mac_ctrl.valid    = p1_ff && !p1_scan_ff;
   assign mac_ctrl.use_elem = LW'(qpos_ff) < len_q;

   tkp_mac #(
      .ELEMENT_BITS (ELEMENT_BITS),
      .EW           (EW)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mac_ctrl),
      .idx      (p1_idx_ff),
      .op_a     (value_ff),
      .op_b     (elem_q),
      .acc      (p1_sum),
      .wr_valid (wr_valid),
      .wr_idx   (wr_idx),
      .wr_sum   (wr_sum)
   );

   assign cmp_ctrl.clear = scan_issue && (i_ff == '0);
   assign cmp_ctrl.valid = p1_ff && p1_scan_ff && !sel_ff[p1_idx_ff];

   tkp_max #(
      .EW (EW)
   ) u_max (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (cmp_ctrl),
      .cand_idx   (p1_idx_ff),
      .cand_score (p1_sum),
      .best_idx   (best_idx),
      .best_score (best_score)
   );

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {{(RSP_DATA_W-TAG_W-SCORE_W){1'b0}}, best_score, tag_q};
   assign rsp_tlast  = (LIMIT_W'(k_ff + LIMIT_W'(1)) == n_ff);

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count past store size");

   a_best_marked: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> sel_ff[best_idx])
      else $error("result entry not marked selected");

   a_query_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (sel_ff == '0 && qpos_ff == '0))
      else $error("query state not cleared after last result");
`endif

endmodule

// ===== rtl/tkp_mac.sv =====
// shared multiply-accumulate unit: product register, then saturating add
// depends on tkp_pkg
module tkp_mac
   import tkp_pkg::*;
#(
   parameter int ELEMENT_BITS = DEF_ELEMENT_BITS,
   parameter int EW = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mac_ctrl_type                   ctrl,
   input  logic [EW-1:0]                  idx,
   input  logic signed [ELEMENT_BITS-1:0] op_a,
   input  logic signed [ELEMENT_BITS-1:0] op_b,
   input  logic signed [SCORE_W-1:0]      acc,
   output logic                           wr_valid,
   output logic [EW-1:0]                  wr_idx,
   output logic signed [SCORE_W-1:0]      wr_sum
);
   localparam int PROD_W = 2 * ELEMENT_BITS;
   localparam int ACC_W  = ((PROD_W > SCORE_W) ? PROD_W : SCORE_W) + 1;
   localparam logic signed [ACC_W-1:0] SMAX = {{(ACC_W-SCORE_W+1){1'b0}}, {(SCORE_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SMIN = {{(ACC_W-SCORE_W+1){1'b1}}, {(SCORE_W-1){1'b0}}};

   logic                     valid_ff, valid_in;
   logic [EW-1:0]            idx_ff, idx_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [SCORE_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0]  sum;

   always_comb begin
      valid_in = ctrl.valid;
      idx_in   = idx;
      acc_in   = acc;
      prod_in  = ctrl.use_elem ? PROD_W'(op_a * op_b) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      idx_ff  <= idx_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_comb begin
      sum = {{(ACC_W-SCORE_W){acc_ff[SCORE_W-1]}}, acc_ff}
          + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      priority if (sum > SMAX) begin
         wr_sum = SMAX[SCORE_W-1:0];
      end else if (sum < SMIN) begin
         wr_sum = SMIN[SCORE_W-1:0];
      end else begin
         wr_sum = sum[SCORE_W-1:0];
      end
   end

   assign wr_valid = valid_ff;
   assign wr_idx   = idx_ff;

endmodule

// ===== rtl/tkp_max.sv =====
// running maximum compare unit; keeps the first index on ties
// depends on tkp_pkg
module tkp_max
   import tkp_pkg::*;
#(
   parameter int EW = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmp_ctrl_type              ctrl,
   input  logic [EW-1:0]             cand_idx,
   input  logic signed [SCORE_W-1:0] cand_score,
   output logic [EW-1:0]             best_idx,
   output logic signed [SCORE_W-1:0] best_score
);
   logic                      found_ff, found_in;
   logic [EW-1:0]             idx_ff, idx_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic                      take;

   always_comb begin
      take     = ctrl.valid && (!found_ff || cand_score > score_ff);
      found_in = ctrl.clear ? 1'b0 : (found_ff || take);
      idx_in   = take ? cand_idx : idx_ff;
      score_in = take ? cand_score : score_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      idx_ff   <= idx_in;
      score_ff <= score_in;
   end

   assign best_idx   = idx_ff;
   assign best_score = score_ff;

endmodule

// ===== tb/tb_dot_product_top_k_search_top.sv =====
// self-checking testbench for dot_product_top_k_search_top: adds, queries, ranking
// depends on tkp_pkg and the rtl of the search block; predicts results in-line
module tb_dot_product_top_k_search_top;
   import tkp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ENTRIES = DEF_MAX_ENTRIES;
   localparam int VEC_LEN     = DEF_VECTOR_LEN;
   localparam int WATCHDOG    = 20000;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [SCORE_W-1:0] score;
      logic               last;
   } ranked_hit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [LIMIT_W-1:0] csr_data = '0;

   always #5 clock = ~clock;

   dot_product_top_k_search_top u_top (.*);

   // predictor state
   logic signed [ELEM_W-1:0]  vec_mem [NUM_ENTRIES][VEC_LEN];
   logic [TAG_W-1:0]          tag_mem [NUM_ENTRIES];
   logic signed [SCORE_W-1:0] sums [NUM_ENTRIES];
   int unsigned               stored_count, fill_pos, query_pos, limit_reg;
   ranked_hit_type            expected_hits [$];

   int errors = 0, words_sent = 0, hits_seen = 0, idle_cycles = 0;

   function automatic void predict_word(logic cmd, logic [TAG_W-1:0] tag,
                                        logic signed [ELEM_W-1:0] e, logic lst);
      logic signed [63:0] s;
      int unsigned n, best;
      bit found;
      logic [NUM_ENTRIES-1:0] taken;
      ranked_hit_type h;
      if (cmd == CMD_ADD) begin
         if (stored_count >= NUM_ENTRIES) return;
         vec_mem[stored_count][fill_pos] = e;
         tag_mem[stored_count] = tag;
         if (lst || fill_pos >= VEC_LEN - 1) begin
            for (int i = fill_pos + 1; i < VEC_LEN; i++) vec_mem[stored_count][i] = '0;
            stored_count++;
            fill_pos = 0;
         end else begin
            fill_pos++;
         end
         return;
      end
      if (query_pos == 0)
         for (int i = 0; i < NUM_ENTRIES; i++) sums[i] = '0;
      for (int i = 0; i < stored_count; i++) begin
         s = 64'(sums[i]) + 64'(e) * 64'(vec_mem[i][query_pos]);
         if (s > 64'sd1099511627775) s = 64'sd1099511627775;
         if (s < -64'sd1099511627776) s = -64'sd1099511627776;
         sums[i] = s[SCORE_W-1:0];
      end
      if (!(lst || query_pos >= VEC_LEN - 1)) begin
         query_pos++;
         return;
      end
      n = (limit_reg < stored_count) ? limit_reg : stored_count;
      taken = '0;
      for (int k = 0; k < n; k++) begin
         best = 0;
         found = 0;
         for (int i = 0; i < stored_count; i++)
            if (!taken[i] && (!found || sums[i] > sums[best])) begin
               best = i;
               found = 1;
            end
         taken[best] = 1'b1;
         h.tag = tag_mem[best];
         h.score = sums[best];
         h.last = (k + 1 == n);
         expected_hits.push_back(h);
      end
      query_pos = 0;
   endfunction

   // result checker with random backpressure
   always @(posedge clock) begin
      ranked_hit_type h;
      if (!reset && rsp_tvalid && rsp_tready) begin
         hits_seen++;
         if (expected_hits.size() == 0) begin
            $error("unexpected result word tag=%0h", rsp_tdata[TAG_W-1:0]);
            errors++;
         end else begin
            h = expected_hits.pop_front();
            if (rsp_tdata[TAG_W-1:0] !== h.tag) begin
               $error("result_tag exp %0h got %0h", h.tag, rsp_tdata[TAG_W-1:0]);
               errors++;
            end
            if (rsp_tdata[TAG_W+SCORE_W-1:TAG_W] !== h.score) begin
               $error("score exp %0h got %0h", h.score, rsp_tdata[TAG_W+SCORE_W-1:TAG_W]);
               errors++;
            end
            if (rsp_tlast !== h.last) begin
               $error("last_result exp %0b got %0b", h.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   int stall_left = 0;
   bit calm = 0;
   always @(negedge clock) begin
      if (rsp_tvalid && rsp_tready) stall_left = calm ? 0 : $urandom_range(0, 18);
      rsp_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
   end

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles = 0;
      else if (++idle_cycles >= WATCHDOG) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // starts and ends at a falling edge; valid stays up between back-to-back words
   task automatic send_word(logic cmd, logic [TAG_W-1:0] tag,
                            logic signed [ELEM_W-1:0] e, logic lst);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tlast  <= lst;
      req_tdata  <= {1'b0, e, tag};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_word(cmd, tag, e, lst);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (3 * NUM_ENTRIES + 20) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_limit(int unsigned v);
      csr_valid <= 1'b1;
      csr_data  <= v[LIMIT_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      limit_reg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // short vector of len elements; lengths stay small to keep queries cheap
   task automatic send_vector(logic cmd, logic [TAG_W-1:0] tag, int len, int mode);
      logic signed [ELEM_W-1:0] e;
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: e = ELEM_W'($urandom);
            1: e = 16'sh7fff;
            2: e = -16'sh8000;
            default: e = ELEM_W'($urandom_range(0, 7) - 3);
         endcase
         send_word(cmd, tag, e, i == len - 1);
      end
   endtask

   task automatic test_directed();
      send_vector(CMD_QUERY, '0, 2, 0);              // empty answer: no entries
      send_vector(CMD_ADD, 31'h7fffffff, 3, 1);
      send_vector(CMD_ADD, 31'h0, 3, 2);
      send_vector(CMD_ADD, 31'h5, 2, 3);             // short vector
      send_vector(CMD_ADD, 31'h6, 2, 3);
      send_vector(CMD_QUERY, '0, 3, 2);              // extremes, zero-filled tail
      send_word(CMD_QUERY, '0, 16'sh7fff, 1'b0);
      send_word(CMD_ADD, 31'h11, 16'sh7fff, 1'b1);   // add during a query
      send_word(CMD_QUERY, '0, 16'sh7fff, 1'b1);
      send_vector(CMD_QUERY, '0, 1, 3);              // ties likely
      drain();
      write_limit(0);                                // empty answer by limit
      send_vector(CMD_QUERY, '0, 2, 0);
      drain();
      write_limit(1);
      send_vector(CMD_QUERY, '0, 2, 0);
      drain();
      write_limit(127);
   endtask

   task automatic test_random(int words);
      int start;
      start = words_sent;
      while (words_sent - start < words) begin
         if ($urandom_range(0, 3) == 0)
            send_vector(CMD_ADD, TAG_W'($urandom), $urandom_range(1, 4),
                        $urandom_range(0, 3));
         else
            send_vector(CMD_QUERY, TAG_W'($urandom), $urandom_range(1, 4),
                        $urandom_range(0, 3));
      end
   endtask

   task automatic test_full_store();
      while (stored_count < NUM_ENTRIES)
         send_vector(CMD_ADD, TAG_W'($urandom), 1, 0);
      send_vector(CMD_ADD, TAG_W'($urandom), 2, 0);  // dropped
      send_vector(CMD_QUERY, '0, 3, 0);
      drain();
      write_limit(NUM_ENTRIES);
      test_random(80);
      drain();
   endtask

   initial begin
      stored_count = 0; fill_pos = 0; query_pos = 0; limit_reg = LIMIT_RESET;
      for (int i = 0; i < NUM_ENTRIES; i++) sums[i] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(150);
      drain();
      write_limit($urandom_range(2, 63));
      test_random(60);
      drain();
      test_full_store();
      $display("run covered %0d request words, %0d ranked results, %0d entries stored",
               words_sent, hits_seen, stored_count);
      if (errors == 0 && expected_hits.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/tkp_pkg.sv
rtl/tkp_mac.sv
rtl/tkp_max.sv
rtl/dot_product_top_k_search_top.sv
tb/tb_dot_product_top_k_search_top.sv
